// File: hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, transfer payload types and the lowest-set-bit helper.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned ROW_SEL_BITS  = 7;
  localparam int unsigned COL_SEL_BITS  = 5;
  localparam int unsigned SLOT_BITS     = ROW_SEL_BITS + COL_SEL_BITS;
  localparam int unsigned NUM_REGIONS   = 4;
  localparam int unsigned REGION_BITS   = 2;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned BIT_IDX_BITS  = 6;
  localparam int unsigned WORD_IDX_BITS = SLOT_BITS - BIT_IDX_BITS;
  localparam int unsigned WORDS_PER_REG = 1 << WORD_IDX_BITS;
  localparam int unsigned MAP_ADDR_BITS = REGION_BITS + WORD_IDX_BITS;
  localparam int unsigned MAP_WORDS     = NUM_REGIONS * WORDS_PER_REG;
  localparam int unsigned ACTIVE_BITS   = 3;
  localparam int unsigned ADDR_BITS     = 14;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_INACTIVE = 2'd2;

  typedef struct packed {
    logic                 mode;
    logic [ADDR_BITS-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] alloc_addr;
    logic [1:0]           status;
  } rsp_t;

  typedef struct packed {
    logic                     rd;
    logic                     wr;
    logic [MAP_ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0]     wdata;
  } map_req_t;

  function automatic logic [BIT_IDX_BITS-1:0] lowest_set(logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_BITS'(i);
    end
    return idx;
  endfunction

endpackage

// File: hdl/bsa_free_map.sv
// ----------------------------------------------------------------------------
// Free bitmap memory
// One synchronous word memory with registered read data. Per-word valid bits
// make a never-written word read as all free.
// ----------------------------------------------------------------------------
module bsa_free_map
  import bsa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  map_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  // Unwritten words read as all ones: every slot free.
  assign rdata_o = rd_vld_q ? rdata_q : '1;

endmodule

// File: hdl/bitmap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator, first fit over regions
// Each request passes through two states, lookup then read-modify-write, before its result is registered.
// A new input transfer is stalled until the read-modify-write of one map word has finished.
// A pending result in the output register does not block the next input transfer.
// Reset: asynchronous; all slots free, region 0 active, no clearing pass needed.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top
  import bsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;

  logic [1:0]               state_q, state_d;
  req_t                     req_q;
  logic [REGION_BITS-1:0]   region_q, region_d;
  logic [WORD_IDX_BITS-1:0] word_q, word_d;
  logic [1:0]               stat_q, stat_d;
  logic [ACTIVE_BITS-1:0]   active_q, active_d;
  logic [WORD_BITS-1:0]     summary_q [NUM_REGIONS];
  logic                     out_valid_q;
  rsp_t                     out_q;

  map_req_t                 map_req;
  logic [WORD_BITS-1:0]     cur_word;
  logic [BIT_IDX_BITS-1:0]  bit_idx;
  logic [WORD_BITS-1:0]     new_word;
  logic                     out_free;
  logic                     finish;
  logic                     found;
  logic [REGION_BITS-1:0]   sel;

  bsa_free_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (map_req),
    .rdata_o (cur_word)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_RMW) && out_free;

  // Lookup: pick region and word from the nonempty-word summary, or take them from the free address.
  always_comb begin
    found    = 1'b0;
    sel      = '0;
    active_d = active_q;
    region_d = region_q;
    word_d   = word_q;
    stat_d   = stat_q;
    if (req_q.mode == MODE_ALLOC) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (!found && (ACTIVE_BITS'(r) < active_q) && (summary_q[r] != '0)) begin
          found = 1'b1;
          sel   = REGION_BITS'(r);
        end
      end
      if (!found && (active_q < ACTIVE_BITS'(NUM_REGIONS))) begin
        // Every active region is full: open the next one.
        active_d = active_q + ACTIVE_BITS'(1);
        sel      = active_q[REGION_BITS-1:0];
        found    = (summary_q[sel] != '0);
      end
      region_d = sel;
      word_d   = lowest_set(summary_q[sel]);
      stat_d   = found ? STATUS_OK : STATUS_FULL;
    end else begin
      region_d = req_q.free_addr[ADDR_BITS-1 -: REGION_BITS];
      word_d   = req_q.free_addr[SLOT_BITS-1 -: WORD_IDX_BITS];
      stat_d   = ({1'b0, region_d} >= active_q) ? STATUS_INACTIVE : STATUS_OK;
    end
  end

  // Modify the word read back from the map.
  always_comb begin
    if (req_q.mode == MODE_FREE) begin
      bit_idx  = req_q.free_addr[BIT_IDX_BITS-1:0];
      new_word = cur_word | (WORD_BITS'(1) << bit_idx);
    end else begin
      bit_idx  = lowest_set(cur_word);
      new_word = cur_word & ~(WORD_BITS'(1) << bit_idx);
    end
  end

  always_comb begin
    map_req.rd    = (state_q == S_LOOK);
    map_req.wr    = finish && (stat_q == STATUS_OK);
    map_req.addr  = (state_q == S_LOOK) ? {region_d, word_d} : {region_q, word_q};
    map_req.wdata = new_word;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LOOK;
      S_LOOK:  state_d = S_RMW;
      S_RMW:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
    if (state_q == S_LOOK) begin
      region_q <= region_d;
      word_q   <= word_d;
      stat_q   <= stat_d;
    end
    if (finish) begin
      out_q.status     <= stat_q;
      out_q.alloc_addr <= ((req_q.mode == MODE_ALLOC) && (stat_q == STATUS_OK)) ?
                          {region_q, word_q, bit_idx} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_BITS'(1);
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        summary_q[r] <= '1;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_LOOK) begin
        active_q <= active_d;
      end
      if (map_req.wr) begin
        summary_q[region_q][word_q] <= (new_word != '0);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q != '0) && (active_q <= ACTIVE_BITS'(NUM_REGIONS)))
    else $error("active region count out of range");

  a_summary_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (req_q.mode == MODE_ALLOC) && (stat_q == STATUS_OK)) |-> (cur_word != '0))
    else $error("summary marked an empty word as nonempty");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_RMW))
    else $error("result appeared without a completed update");

endmodule

// File: tb/bitmap_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Sends allocate and free transfers with random gaps and output stalls. A
// bitmap predictor computes each expected result at input acceptance, and
// every output transfer is checked in order against it. Directed corner
// cases come first, then a random mix of allocations and frees.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top_tb;
  import bsa_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 590;
  localparam int unsigned HOLD_CYCLES  = 200;

  class alloc_scoreboard;
    logic [WORD_BITS-1:0] free_map [NUM_REGIONS][WORDS_PER_REG];
    int unsigned          active_cnt;
    rsp_t                 pending[$];
    logic [ADDR_BITS-1:0] live[$];
    int unsigned          n_errors;
    int unsigned          n_accepted;

    function new();
      foreach (free_map[r, w]) free_map[r][w] = '1;
      active_cnt = 1;
      n_errors   = 0;
      n_accepted = 0;
    endfunction

    // Take the lowest free slot of one region, if it has any.
    function bit claim_slot(int unsigned rg, output logic [SLOT_BITS-1:0] slot);
      slot = '0;
      for (int w = 0; w < WORDS_PER_REG; w++) begin
        if (free_map[rg][w] != '0) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (free_map[rg][w][b]) begin
              free_map[rg][w][b] = 1'b0;
              slot = SLOT_BITS'(w * WORD_BITS + b);
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(req_t req);
      rsp_t                 want;
      logic [SLOT_BITS-1:0] slot;
      int unsigned          rg;
      bit                   found;
      want.alloc_addr = '0;
      want.status     = STATUS_OK;
      found           = 1'b0;
      slot            = '0;
      n_accepted++;
      if (req.mode == MODE_ALLOC) begin
        rg = 0;
        while (!found && rg < active_cnt) begin
          found = claim_slot(rg, slot);
          if (!found) rg++;
        end
        // every active region full: open the next one
        if (!found && active_cnt < NUM_REGIONS) begin
          rg = active_cnt;
          active_cnt++;
          found = claim_slot(rg, slot);
        end
        if (found) begin
          want.alloc_addr = ADDR_BITS'((rg << SLOT_BITS) | slot);
          live.insert(live.size(), want.alloc_addr);
        end else begin
          want.status = STATUS_FULL;
        end
      end else begin
        rg = int'(req.free_addr[ADDR_BITS-1:SLOT_BITS]);
        if (rg >= active_cnt) begin
          want.status = STATUS_INACTIVE;
        end else begin
          free_map[rg][req.free_addr[SLOT_BITS-1:BIT_IDX_BITS]]
                      [req.free_addr[BIT_IDX_BITS-1:0]] = 1'b1;
        end
      end
      pending.insert(pending.size(), want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: alloc_addr %0h status %0d",
               got.alloc_addr, got.status);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      if (got.alloc_addr !== want.alloc_addr) begin
        $error("alloc_addr expected %0h actual %0h", want.alloc_addr, got.alloc_addr);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid    = 1'b0;
  logic out_stall   = 1'b0;
  req_t in_data     = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;

  alloc_scoreboard sb;

  bitmap_slot_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_request(in_data);
      if (out_valid_o && !out_stall) sb.check_response(out_data_o);
    end
  end

  // Both sides run without gaps through this stretch of transfers.
  function automatic bit is_calm();
    return sb.n_accepted >= 300 && sb.n_accepted < 520;
  endfunction

  function automatic req_t make_req(logic mode, logic [ADDR_BITS-1:0] addr);
    req_t r;
    r.mode      = mode;
    r.free_addr = addr;
    return r;
  endfunction

  // Called at a falling edge; returns at the rising edge of the transfer.
  task automatic drive_request(req_t r);
    if (!is_calm() && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send(logic mode, logic [ADDR_BITS-1:0] addr);
    @(negedge clk_i);
    drive_request(make_req(mode, addr));
  endtask

  // Mix of allocations, frees of held slots and frees of arbitrary addresses.
  task automatic pick_and_drive(int unsigned alloc_pct);
    int unsigned          p;
    int unsigned          idx;
    logic [ADDR_BITS-1:0] addr;
    p    = $urandom_range(99);
    addr = ADDR_BITS'($urandom);
    if (p < alloc_pct) begin
      drive_request(make_req(MODE_ALLOC, addr));
    end else if (p < alloc_pct + (100 - alloc_pct) * 2 / 3 && sb.live.size() > 0) begin
      idx  = $urandom_range(sb.live.size() - 1);
      addr = sb.live[idx];
      sb.live.delete(idx);
      drive_request(make_req(MODE_FREE, addr));
    end else begin
      drive_request(make_req(MODE_FREE, addr));
    end
  endtask

  // Receiver: random stalls, one long hold-off once traffic is under way.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sb.n_accepted >= 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall <= !is_calm() && $urandom_range(99) < 6;
      end
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(MODE_ALLOC, 14'h0000);
    send(MODE_ALLOC, 14'h3FFF);          // address ignored on allocate
    send(MODE_FREE,  14'h0000);
    send(MODE_ALLOC, 14'h2AAA);
    send(MODE_FREE,  14'h0005);          // already free
    send(MODE_FREE,  14'h3FFF);          // region not yet active
    send(MODE_FREE,  14'h1000);
    send(MODE_FREE,  14'h2000);
    send(MODE_FREE,  14'h0FFF);          // last slot of region 0
    send(MODE_ALLOC, 14'h1555);
    send(MODE_FREE,  14'h0001);
    send(MODE_FREE,  14'h0001);          // double free
    send(MODE_ALLOC, 14'h0000);
    send(MODE_ALLOC, 14'h0000);
    send(MODE_FREE,  14'h0040);          // first slot of the second word
    send(MODE_FREE,  14'h003F);
    send(MODE_ALLOC, 14'h0000);
    send(MODE_FREE,  14'h0002);
    send(MODE_ALLOC, 14'h0FFF);

    repeat (RANDOM_ITEMS) begin
      @(negedge clk_i);
      pick_and_drive(55);
    end

    repeat (40) begin
      @(negedge clk_i);
      pick_and_drive(40);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: 10 ms, far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
